FILE: sv/lgge_pkg.sv
// Shared types and constants of the life grid generation engine.
package lgge_pkg;

    localparam int unsigned CFG_W     = 7;
    localparam int unsigned COORD_W   = 6;
    localparam int unsigned ROW_OUT_W = 64;

    typedef enum logic [1:0] {
        OP_TOGGLE = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_STEP   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic [0:0] CFG_COLS = 1'b0;
    localparam logic [0:0] CFG_ROWS = 1'b1;

    localparam logic [CFG_W-1:0] COLS_RESET = 7'd40;
    localparam logic [CFG_W-1:0] ROWS_RESET = 7'd30;

    // B3/S23 neighbor counts.
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] cell_col;
        logic [COORD_W-1:0] cell_row;
    } lgge_req_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row_bits;
        logic                 cell_now;
    } lgge_rsp_t;

endpackage

FILE: sv/lgge_row_unit.sv
// Next-generation rule for one grid row from a three-row window.
module lgge_row_unit
    import lgge_pkg::*;
#(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0] up_row,
    input  logic [COLS-1:0] mid_row,
    input  logic [COLS-1:0] dn_row,
    input  logic [COLS-1:0] col_mask,
    output logic [COLS-1:0] next_row
);

    logic [COLS-1:0] up_l;
    logic [COLS-1:0] up_r;
    logic [COLS-1:0] mid_l;
    logic [COLS-1:0] mid_r;
    logic [COLS-1:0] dn_l;
    logic [COLS-1:0] dn_r;

    // Bit c of a left-shifted word holds column c-1, of a right-shifted word
    // column c+1; the shifts bring in dead cells at both edges.
    assign up_l  = up_row << 1;
    assign up_r  = up_row >> 1;
    assign mid_l = mid_row << 1;
    assign mid_r = mid_row >> 1;
    assign dn_l  = dn_row << 1;
    assign dn_r  = dn_row >> 1;

    for (genvar c = 0; c < COLS; c++) begin : g_col
        logic [3:0] nbr;

        assign nbr = 4'(up_l[c]) + 4'(up_row[c]) + 4'(up_r[c])
                   + 4'(mid_l[c]) + 4'(mid_r[c])
                   + 4'(dn_l[c]) + 4'(dn_row[c]) + 4'(dn_r[c]);

        assign next_row[c] = col_mask[c]
                           & ((nbr == BIRTH_COUNT) | (mid_row[c] & (nbr == SURVIVE_COUNT)));
    end

endmodule

FILE: sv/life_grid_generation_engine_unit.sv
// Life grid engine: a cell grid in one memory that is toggled, cleared, stepped and read.
//
// The grid lives in a memory of MAX_ROWS words of MAX_COLS bits with one write and one
// registered read port, and each request produces exactly one response. Toggle and read row
// first read the addressed row into a register and then answer. Clear writes every row once.
// A generation step sweeps the memory one row per cycle through a three-row window and one
// shared row rule unit, writing each new row back in place. After reset a clearing pass runs
// with req_ready low; configuration writes are taken at any time. req_ready is high only
// while no request is in progress, and a finished response waits in an output register.
module life_grid_generation_engine_unit
    import lgge_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  lgge_req_t        req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output lgge_rsp_t        rsp_data,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CNTW = $clog2(MAX_ROWS + 1);
    localparam int NW   = (CNTW > CFG_W) ? CNTW : CFG_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CLEAR  = 6'b000010,
        ST_TOGGLE = 6'b000100,
        ST_READ   = 6'b001000,
        ST_STEP   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    cols_cfg_reg, cols_cfg_next;
    logic [CFG_W-1:0]    rows_cfg_reg, rows_cfg_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic                iss_reg, iss_next;
    logic                clr_rsp_reg, clr_rsp_next;
    logic                s1_vld_reg, s1_vld_next;
    logic                s2_vld_reg, s2_vld_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [CNTW-1:0]     s1_idx_reg, s1_idx_next;
    logic [CNTW-1:0]     s2_idx_reg, s2_idx_next;
    logic [MAX_COLS-1:0] up_reg, up_next;
    logic [MAX_COLS-1:0] mid_reg, mid_next;
    logic [MAX_COLS-1:0] dn_reg, dn_next;
    lgge_req_t           req_reg, req_next;
    lgge_rsp_t           rsp_data_reg, rsp_data_next;
    logic [MAX_COLS-1:0] rdata_reg;

    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];

    logic                rd_en;
    logic [RW-1:0]       rd_addr;
    logic                wr_en;
    logic [RW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    logic [CFG_W-1:0]    eff_cols;
    logic [NW-1:0]       eff_rows;
    logic [NW-1:0]       rows_ext;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] tgl_mask;
    logic [MAX_COLS-1:0] new_row;
    logic [NW-1:0]       in_row_ext;
    logic [NW-1:0]       req_row_ext;
    logic [CNTW-1:0]     s2_dec;
    logic                req_acc;
    logic                out_free;
    logic                out_load;
    lgge_rsp_t           out_val;
    logic                row_ok;
    logic                cell_ok;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Register values out of range are clamped to the grid that exists.
    assign rows_ext = NW'(rows_cfg_reg);

    always_comb
    begin
        if (cols_cfg_reg == '0)
            eff_cols = CFG_W'(1);
        else if (cols_cfg_reg > CFG_W'(MAX_COLS))
            eff_cols = CFG_W'(MAX_COLS);
        else
            eff_cols = cols_cfg_reg;

        if (rows_ext == '0)
            eff_rows = NW'(1);
        else if (rows_ext > NW'(MAX_ROWS))
            eff_rows = NW'(MAX_ROWS);
        else
            eff_rows = rows_ext;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_COLS; i++)
        begin
            col_mask[i] = (CFG_W'(i) < eff_cols);
            tgl_mask[i] = ({1'b0, req_reg.cell_col} == CFG_W'(i));
        end
    end

    assign in_row_ext  = NW'(req_data.cell_row);
    assign req_row_ext = NW'(req_reg.cell_row);
    assign s2_dec      = s2_idx_reg - CNTW'(1);
    assign row_ok      = (req_row_ext < eff_rows);
    assign cell_ok     = row_ok && ({1'b0, req_reg.cell_col} < eff_cols);

    lgge_row_unit #(
        .COLS (MAX_COLS)
    ) u_row_unit (
        .up_row   (up_reg),
        .mid_row  (mid_reg),
        .dn_row   (dn_reg),
        .col_mask (col_mask),
        .next_row (new_row)
    );

    always_comb
    begin
        state_next    = state_reg;
        cols_cfg_next = cols_cfg_reg;
        rows_cfg_next = rows_cfg_reg;
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        clr_rsp_next  = clr_rsp_reg;
        s1_vld_next   = 1'b0;
        s1_idx_next   = cnt_reg;
        s2_vld_next   = s1_vld_reg;
        s2_idx_next   = s1_idx_reg;
        up_next       = up_reg;
        mid_next      = mid_reg;
        dn_next       = dn_reg;
        req_next      = req_reg;
        rd_en         = 1'b0;
        rd_addr       = in_row_ext[RW-1:0];
        wr_en         = 1'b0;
        wr_addr       = req_row_ext[RW-1:0];
        wr_data       = '0;
        out_load      = 1'b0;
        out_val       = '0;

        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_COLS: cols_cfg_next = cfg_wdata;
                CFG_ROWS: rows_cfg_next = cfg_wdata;
                default:  ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    req_next = req_data;
                    case (req_data.op)
                        OP_TOGGLE:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_TOGGLE;
                        end
                        OP_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            cnt_next     = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        OP_STEP:
                        begin
                            cnt_next   = '0;
                            iss_next   = 1'b1;
                            up_next    = '0;
                            mid_next   = '0;
                            dn_next    = '0;
                            state_next = ST_STEP;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_TOGGLE:
            begin
                if (out_free)
                begin
                    if (cell_ok)
                    begin
                        wr_en            = 1'b1;
                        wr_data          = rdata_reg ^ tgl_mask;
                        out_val.cell_now = |(tgl_mask & ~rdata_reg);
                    end
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    if (row_ok)
                        out_val.row_bits = ROW_OUT_W'(rdata_reg & col_mask);
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[RW-1:0];
                wr_data = '0;
                if (cnt_reg == CNTW'(MAX_ROWS - 1))
                    state_next = clr_rsp_reg ? ST_DONE : ST_IDLE;
                else
                    cnt_next = cnt_reg + CNTW'(1);
            end

            ST_STEP:
            begin
                // One extra read slot past the last row shifts a dead row into the
                // window so that the last row gets computed too.
                if (iss_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = cnt_reg[RW-1:0];
                    s1_vld_next = 1'b1;
                    s1_idx_next = cnt_reg;
                    if (cnt_reg == CNTW'(MAX_ROWS))
                        iss_next = 1'b0;
                    else
                        cnt_next = cnt_reg + CNTW'(1);
                end

                if (s1_vld_reg)
                begin
                    up_next  = mid_reg;
                    mid_next = dn_reg;
                    dn_next  = (NW'(s1_idx_reg) < eff_rows) ? (rdata_reg & col_mask) : '0;
                end

                // The window now holds the old rows around row s2_idx - 1, which has
                // already been read and can be overwritten.
                if (s2_vld_reg && (s2_idx_reg != '0))
                begin
                    wr_en   = 1'b1;
                    wr_addr = s2_dec[RW-1:0];
                    wr_data = (NW'(s2_idx_reg) <= eff_rows) ? new_row : '0;
                end

                if (s2_vld_reg && (s2_idx_reg == CNTW'(MAX_ROWS)))
                    state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    clr_rsp_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = out_val;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && !rsp_ready;
            rsp_data_next  = rsp_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cols_cfg_reg  <= COLS_RESET;
            rows_cfg_reg  <= ROWS_RESET;
            cnt_reg       <= '0;
            iss_reg       <= 1'b0;
            clr_rsp_reg   <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_cfg_reg  <= cols_cfg_next;
            rows_cfg_reg  <= rows_cfg_next;
            cnt_reg       <= cnt_next;
            iss_reg       <= iss_next;
            clr_rsp_reg   <= clr_rsp_next;
            s1_vld_reg    <= s1_vld_next;
            s2_vld_reg    <= s2_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        up_reg       <= up_next;
        mid_reg      <= mid_next;
        dn_reg       <= dn_next;
        req_reg      <= req_next;
        rsp_data_reg <= rsp_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= grid_mem[rd_addr];
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("response loaded over one not yet taken");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("ready right after a request was accepted");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_TOGGLE
                               || $past(state_reg) == ST_READ
                               || $past(state_reg) == ST_DONE))
        else $error("response raised outside a finishing state");

    a_step_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == ST_STEP) |-> (s2_idx_reg != '0
                                           && s2_idx_reg <= CNTW'(MAX_ROWS)))
        else $error("generation write outside the grid");

endmodule
